// ----- sv/eems_pkg.sv -----
// Shared types and constants for the explore/exploit prefetch mode selector.
// No dependencies; used by every module of the block.
`default_nettype none

package eems_pkg;

    localparam int MODE_W  = 2;
    localparam int EPOCH_W = 32;
    localparam int CYCLE_W = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPLOIT_EPOCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXPLORE_EPOCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HYSTERESIS    = 2'd2;

    localparam logic [EPOCH_W-1:0] EXPLOIT_EPOCH_RST = 32'd1000000;
    localparam logic [EPOCH_W-1:0] EXPLORE_EPOCH_RST = 32'd10000;

    localparam logic [MODE_W-1:0] MODE_BOTH_ON  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DATA_OFF = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DRAM_OFF = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BOTH_OFF = 2'd3;

    typedef struct packed {
        logic [EPOCH_W-1:0] exploit_epoch;
        logic [EPOCH_W-1:0] explore_epoch;
        logic               hysteresis_enable;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/explore_exploit_mode_selector.sv -----
// Explore/exploit prefetch mode selector: top level with input and result registers.
// Depends on eems_pkg, eems_cfg and eems_step.
//
// Each item on the s_ channel is one retired instruction with the core cycle at
// retirement. Each item produces exactly one result on the m_ channel: the mode
// and phase in force after that instruction, plus the two prefetch disable flags.
// Four modes are measured for explore_epoch instructions each; the cheapest one
// (lowest index on ties, optionally filtered by a confidence counter) then holds
// for exploit_epoch instructions.
// An accepted item waits in the input register and moves into the result register,
// raising m_valid, as soon as the result side is free.
// Throughput: one item per cycle while m_ready stays high; the per-item update is a
// 64-bit subtract and compare against a running minimum.
// The input register refills while the result register is emptied, so s_ready
// stays high under continuous flow. When m_ready is low with a result waiting, both
// registers hold and s_ready drops once the input register is full.
// Reset (aresetn low, synchronous) empties both registers, loads the default
// epochs, and restarts exploration at mode 0. Configuration writes apply at once
// and are meant for idle periods.
`default_nettype none

module explore_exploit_mode_selector #(
    parameter int unsigned CONFIDENCE_MAX = 3
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [eems_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [eems_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [eems_pkg::CYCLE_W-1:0]       s_core_cycle,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_disable_dram_prefetch,
    output logic                                    m_disable_data_prefetch,
    output logic                                    m_exploit_phase,
    output logic [eems_pkg::MODE_W-1:0]             m_active_mode
);

    eems_pkg::cfg_t cfg;

    logic                           in_valid_reg;
    logic [eems_pkg::CYCLE_W-1:0]   in_cycle_reg;
    logic                           out_valid_reg;
    logic [eems_pkg::MODE_W-1:0]    out_mode_reg;
    logic                           out_exploit_reg;

    logic                           advance;
    logic [eems_pkg::MODE_W-1:0]    mode_next;
    logic                           exploit_next;

    eems_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    eems_step #(
        .CONFIDENCE_MAX (CONFIDENCE_MAX)
    ) u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .core_cycle   (in_cycle_reg),
        .cfg          (cfg),
        .mode_next    (mode_next),
        .exploit_next (exploit_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cycle_reg <= s_core_cycle;
        end
        if (advance) begin
            out_mode_reg    <= mode_next;
            out_exploit_reg <= exploit_next;
        end
    end

    assign m_valid                 = out_valid_reg;
    assign m_active_mode           = out_mode_reg;
    assign m_exploit_phase         = out_exploit_reg;
    assign m_disable_dram_prefetch = out_mode_reg[1];
    assign m_disable_data_prefetch = out_mode_reg[0];

endmodule

`default_nettype wire

// ----- sv/eems_cfg.sv -----
// Configuration register file of the mode selector.
// Depends on eems_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module eems_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [eems_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [eems_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output eems_pkg::cfg_t                        cfg
);

    eems_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.exploit_epoch     <= eems_pkg::EXPLOIT_EPOCH_RST;
            cfg_reg.explore_epoch     <= eems_pkg::EXPLORE_EPOCH_RST;
            cfg_reg.hysteresis_enable <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                eems_pkg::CFG_IDX_EXPLOIT_EPOCH: cfg_reg.exploit_epoch <= cfg_wdata;
                eems_pkg::CFG_IDX_EXPLORE_EPOCH: cfg_reg.explore_epoch <= cfg_wdata;
                eems_pkg::CFG_IDX_HYSTERESIS:    cfg_reg.hysteresis_enable <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/eems_step.sv -----
// Phase/mode state and per-item update of the mode selector.
// Keeps a running minimum of per-mode cycle counts; depends on eems_pkg.
`default_nettype none

module eems_step #(
    parameter int unsigned CONFIDENCE_MAX = 3
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           fire,
    input  wire logic [eems_pkg::CYCLE_W-1:0]   core_cycle,
    input  wire eems_pkg::cfg_t                 cfg,
    output logic [eems_pkg::MODE_W-1:0]         mode_next,
    output logic                                exploit_next
);

    localparam int CONF_W = $clog2(CONFIDENCE_MAX + 1);
    localparam logic [CONF_W-1:0] CONF_MAX_C = CONF_W'(CONFIDENCE_MAX);

    logic                            phase_reg;
    logic [eems_pkg::MODE_W-1:0]     mode_reg;
    logic [eems_pkg::EPOCH_W-1:0]    cnt_reg, cnt_next;
    logic [eems_pkg::CYCLE_W-1:0]    start_reg, start_next;
    logic [eems_pkg::CYCLE_W-1:0]    best_val_reg, best_val_next;
    logic [eems_pkg::MODE_W-1:0]     best_idx_reg, best_idx_next;
    logic [eems_pkg::MODE_W-1:0]     prev_win_reg, prev_win_next;
    logic [CONF_W-1:0]               conf_reg, conf_next;

    logic [eems_pkg::EPOCH_W-1:0]    cnt_inc;
    logic [eems_pkg::CYCLE_W-1:0]    diff;
    logic                            diff_lt;
    logic                            explore_end;
    logic                            exploit_end;
    logic [eems_pkg::MODE_W-1:0]     min_idx;
    logic [eems_pkg::MODE_W-1:0]     winner;

    always_comb begin
        cnt_inc     = cnt_reg + 1'b1;
        diff        = core_cycle - start_reg;
        diff_lt     = diff < best_val_reg;
        explore_end = !phase_reg && (cnt_inc >= cfg.explore_epoch);
        exploit_end = phase_reg && (cnt_inc >= cfg.exploit_epoch);
        min_idx     = diff_lt ? eems_pkg::MODE_BOTH_OFF : best_idx_reg;

        winner        = min_idx;
        prev_win_next = prev_win_reg;
        conf_next     = conf_reg;
        if (cfg.hysteresis_enable) begin
            if (min_idx == prev_win_reg) begin
                if (conf_reg < CONF_MAX_C) begin
                    conf_next = conf_reg + 1'b1;
                end
            end else if (conf_reg != '0) begin
                winner    = prev_win_reg;
                conf_next = conf_reg - 1'b1;
            end else begin
                prev_win_next = min_idx;
            end
        end

        exploit_next  = phase_reg;
        mode_next     = mode_reg;
        cnt_next      = cnt_inc;
        start_next    = start_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        if (exploit_end) begin
            exploit_next = 1'b0;
            mode_next    = eems_pkg::MODE_BOTH_ON;
            cnt_next     = '0;
            start_next   = core_cycle;
        end else if (explore_end) begin
            cnt_next   = '0;
            start_next = core_cycle;
            if (mode_reg == eems_pkg::MODE_BOTH_OFF) begin
                exploit_next = 1'b1;
                mode_next    = winner;
            end else begin
                mode_next = mode_reg + 1'b1;
                // first mode of a round seeds the running minimum; ties keep lower index
                if (mode_reg == eems_pkg::MODE_BOTH_ON || diff_lt) begin
                    best_val_next = diff;
                    best_idx_next = mode_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= 1'b0;
            mode_reg     <= eems_pkg::MODE_BOTH_ON;
            cnt_reg      <= '0;
            start_reg    <= '0;
            prev_win_reg <= eems_pkg::MODE_BOTH_OFF;
            conf_reg     <= '0;
        end else if (fire) begin
            phase_reg <= exploit_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            if (explore_end && mode_reg == eems_pkg::MODE_BOTH_OFF) begin
                prev_win_reg <= prev_win_next;
                conf_reg     <= conf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            best_val_reg <= best_val_next;
            best_idx_reg <= best_idx_next;
        end
    end

    a_conf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        conf_reg <= CONF_MAX_C)
        else $error("confidence above its maximum");

    a_exploit_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && explore_end && mode_reg == eems_pkg::MODE_BOTH_OFF |=> phase_reg)
        else $error("last explore epoch did not enter exploit");

    a_explore_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(phase_reg) |-> mode_reg == eems_pkg::MODE_BOTH_ON)
        else $error("exploration did not restart at first mode");

    a_hold_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(mode_reg) && $stable(phase_reg) && $stable(cnt_reg))
        else $error("state moved without an item");

endmodule

`default_nettype wire

// ----- verif/eems_mode_checker.sv -----
`timescale 1ns / 1ps
// Checker for the explore/exploit mode selector: follows register writes, predicts one
// mode report per retired instruction and compares it with the m_ channel in order.
// Depends on eems_pkg; instantiated beside the block by explore_exploit_mode_selector_tb.
module eems_mode_checker #(
    parameter int unsigned CONFIDENCE_MAX = 3
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [eems_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [eems_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [eems_pkg::CYCLE_W-1:0]       s_core_cycle,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_disable_dram_prefetch,
    input  logic                               m_disable_data_prefetch,
    input  logic                               m_exploit_phase,
    input  logic [eems_pkg::MODE_W-1:0]        m_active_mode,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 checked
);

    typedef struct packed {
        logic                        dram_off;
        logic                        data_off;
        logic                        exploit;
        logic [eems_pkg::MODE_W-1:0] mode;
    } mode_report_t;

    logic [eems_pkg::EPOCH_W-1:0] exploit_len;
    logic [eems_pkg::EPOCH_W-1:0] explore_len;
    logic                         hyst_on;

    logic                         exploiting;
    logic [eems_pkg::MODE_W-1:0]  cur_mode;
    logic [eems_pkg::EPOCH_W-1:0] instr_cnt;
    logic [eems_pkg::CYCLE_W-1:0] epoch_start;
    logic [eems_pkg::CYCLE_W-1:0] mode_cost [4];
    logic [eems_pkg::MODE_W-1:0]  prev_winner;
    int unsigned                  confidence;

    mode_report_t reports_due[$];

    // Cheapest mode, lowest index on ties, then the confidence filter when hysteresis is on.
    function logic [eems_pkg::MODE_W-1:0] pick_winner();
        logic [eems_pkg::MODE_W-1:0] best;
        best = eems_pkg::MODE_BOTH_ON;
        for (int i = 1; i < 4; i++)
            if (mode_cost[i] < mode_cost[best])
                best = i[eems_pkg::MODE_W-1:0];
        if (hyst_on) begin
            if (best == prev_winner) begin
                if (confidence < CONFIDENCE_MAX)
                    confidence++;
            end else if (confidence > 0) begin
                best = prev_winner;
                confidence--;
            end else begin
                prev_winner = best;
                confidence = 0;
            end
        end
        return best;
    endfunction

    function mode_report_t retire_instr(input logic [eems_pkg::CYCLE_W-1:0] now);
        mode_report_t r;
        instr_cnt = instr_cnt + 1'b1;
        if (exploiting) begin
            if (instr_cnt >= exploit_len) begin
                exploiting = 1'b0;
                cur_mode = eems_pkg::MODE_BOTH_ON;
                instr_cnt = '0;
                epoch_start = now;
                foreach (mode_cost[i]) mode_cost[i] = '0;
            end
        end else if (instr_cnt >= explore_len) begin
            mode_cost[cur_mode] = now - epoch_start;
            if (cur_mode == eems_pkg::MODE_BOTH_OFF) begin
                exploiting = 1'b1;
                cur_mode = pick_winner();
                foreach (mode_cost[i]) mode_cost[i] = '0;
            end else begin
                cur_mode = cur_mode + 1'b1;
            end
            instr_cnt = '0;
            epoch_start = now;
        end
        r.dram_off = (cur_mode == eems_pkg::MODE_DRAM_OFF) ||
                     (cur_mode == eems_pkg::MODE_BOTH_OFF);
        r.data_off = (cur_mode == eems_pkg::MODE_DATA_OFF) ||
                     (cur_mode == eems_pkg::MODE_BOTH_OFF);
        r.exploit  = exploiting;
        r.mode     = cur_mode;
        return r;
    endfunction

    task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
        fail_count++;
        $display("%0t: result %0d %s: expected %0h, got %0h", $time, checked, what, want, got);
    endtask

    always @(posedge aclk) begin : track
        mode_report_t want;
        if (!aresetn) begin
            exploit_len = eems_pkg::EXPLOIT_EPOCH_RST;
            explore_len = eems_pkg::EXPLORE_EPOCH_RST;
            hyst_on     = 1'b0;
            exploiting  = 1'b0;
            cur_mode    = eems_pkg::MODE_BOTH_ON;
            instr_cnt   = '0;
            epoch_start = '0;
            foreach (mode_cost[i]) mode_cost[i] = '0;
            prev_winner = eems_pkg::MODE_BOTH_OFF;
            confidence  = 0;
            reports_due.delete();
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    eems_pkg::CFG_IDX_EXPLOIT_EPOCH: exploit_len = cfg_wdata;
                    eems_pkg::CFG_IDX_EXPLORE_EPOCH: explore_len = cfg_wdata;
                    eems_pkg::CFG_IDX_HYSTERESIS:    hyst_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                reports_due.push_back(retire_instr(s_core_cycle));
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    report_mismatch("arrived with no item outstanding", '0, '0);
                end else begin
                    want = reports_due.pop_front();
                    if (m_disable_dram_prefetch !== want.dram_off)
                        report_mismatch("disable_dram_prefetch", want.dram_off,
                                        m_disable_dram_prefetch);
                    if (m_disable_data_prefetch !== want.data_off)
                        report_mismatch("disable_data_prefetch", want.data_off,
                                        m_disable_data_prefetch);
                    if (m_exploit_phase !== want.exploit)
                        report_mismatch("exploit_phase", want.exploit, m_exploit_phase);
                    if (m_active_mode !== want.mode)
                        report_mismatch("active_mode", want.mode, m_active_mode);
                    checked++;
                end
            end
            pending <= reports_due.size();
        end
    end

endmodule

// ----- verif/explore_exploit_mode_selector_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for explore_exploit_mode_selector: drives retired-instruction items and
// register settings with random idling, and gives the verdict.
// Depends on eems_pkg, the block itself and eems_mode_checker.
module explore_exploit_mode_selector_tb;

    localparam int unsigned CONF_MAX    = 3;
    localparam int          IDLE_LIMIT  = 2000;
    localparam int          RAND_PHASES = 7;
    localparam int          PHASE_ITEMS = 150;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [eems_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [eems_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_valid = 1'b0;
    logic [eems_pkg::CYCLE_W-1:0]    s_core_cycle = '0;
    logic                            m_ready = 1'b0;
    logic                            s_ready;
    logic                            m_valid;
    logic                            m_disable_dram_prefetch;
    logic                            m_disable_data_prefetch;
    logic                            m_exploit_phase;
    logic [eems_pkg::MODE_W-1:0]     m_active_mode;

    int                           fail_count;
    int                           pending;
    int                           checked;
    int                           items_sent = 0;
    int                           settings_used = 1;
    int                           idle_cycles = 0;
    int                           stall_left = 0;
    bit                           calm = 1'b0;
    logic [eems_pkg::CYCLE_W-1:0] cycle_now = '0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    explore_exploit_mode_selector #(
        .CONFIDENCE_MAX(CONF_MAX)
    ) u_top (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_wr_en               (cfg_wr_en),
        .cfg_index               (cfg_index),
        .cfg_wdata               (cfg_wdata),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_core_cycle            (s_core_cycle),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_disable_dram_prefetch (m_disable_dram_prefetch),
        .m_disable_data_prefetch (m_disable_data_prefetch),
        .m_exploit_phase         (m_exploit_phase),
        .m_active_mode           (m_active_mode)
    );

    eems_mode_checker #(
        .CONFIDENCE_MAX(CONF_MAX)
    ) u_checker (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_wr_en               (cfg_wr_en),
        .cfg_index               (cfg_index),
        .cfg_wdata               (cfg_wdata),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_core_cycle            (s_core_cycle),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_disable_dram_prefetch (m_disable_dram_prefetch),
        .m_disable_data_prefetch (m_disable_data_prefetch),
        .m_exploit_phase         (m_exploit_phase),
        .m_active_mode           (m_active_mode),
        .fail_count              (fail_count),
        .pending                 (pending),
        .checked                 (checked)
    );

    // Result side: back-pressure in random bursts, off in the calm last phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic set_config(input logic [eems_pkg::EPOCH_W-1:0] exploit_len,
                              input logic [eems_pkg::EPOCH_W-1:0] explore_len,
                              input bit hyst);
        logic [eems_pkg::CFG_DATA_W-1:0] hyst_word;
        hyst_word = $urandom;
        hyst_word[0] = hyst;
        cfg_wr_en <= 1'b1;
        cfg_index <= eems_pkg::CFG_IDX_EXPLOIT_EPOCH;
        cfg_wdata <= exploit_len;
        @(posedge aclk);
        cfg_index <= eems_pkg::CFG_IDX_EXPLORE_EPOCH;
        cfg_wdata <= explore_len;
        @(posedge aclk);
        cfg_index <= eems_pkg::CFG_IDX_HYSTERESIS;
        cfg_wdata <= hyst_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic retire(input logic [eems_pkg::CYCLE_W-1:0] cyc);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_core_cycle <= cyc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Mostly small steps so modes tie and differ; rare jumps and full reloads.
    function logic [eems_pkg::CYCLE_W-1:0] next_cycle();
        case ($urandom_range(0, 39))
            0:       cycle_now = {$urandom, $urandom};
            1, 2, 3: cycle_now = cycle_now + $urandom_range(0, 5000);
            default: cycle_now = cycle_now + $urandom_range(0, 3);
        endcase
        return cycle_now;
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // default epochs, extreme cycle values
        retire(64'd0);
        retire('1);
        retire(64'h8000_0000_0000_0000);
        drain();

        // zero explore epoch lowered mid-phase: every item ends an epoch;
        // wrapped and zero cycle differences
        set_config(32'd1, 32'd0, 1'b0);
        retire(64'd5);
        retire(64'd3);
        retire(64'd3);
        retire(64'd10);
        retire(64'd12);
        retire(64'd20);
        drain();

        // all-ones exploit epoch: once in exploit, stays there
        set_config('1, 32'd1, 1'b1);
        retire(64'd100);
        retire(64'd101);
        retire(64'd101);
        retire(64'd105);
        retire(64'd106);
        retire('1);
        drain();

        // exploit epoch lowered mid-phase, then all-ones explore epoch
        set_config(32'd2, '1, 1'b1);
        retire(64'd7);
        retire(64'd8);
        retire(64'd0);
        drain();

        // explore epoch lowered mid-phase, zero exploit epoch
        set_config(32'd0, 32'd1, 1'b1);
        repeat (5) retire(next_cycle());

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            drain();
            calm = (phase == RAND_PHASES - 1);
            set_config($urandom_range(1, 12), $urandom_range(1, 6), (phase % 3) != 0);
            repeat (PHASE_ITEMS) retire(next_cycle());
        end
        drain();
        repeat (6) @(posedge aclk);

        $display("run covered %0d instructions, %0d results compared, %0d register settings",
                 items_sent, checked, settings_used);
        $display("settings spanned zero and all-ones epochs, hysteresis on and off");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- explore_exploit_mode_selector.f -----
sv/eems_pkg.sv
sv/eems_cfg.sv
sv/eems_step.sv
sv/explore_exploit_mode_selector.sv
verif/eems_mode_checker.sv
verif/explore_exploit_mode_selector_tb.sv
